// File: src/nmof_pkg.sv
// Shared constants, types and helpers of the neighbor-mean outlier filter.
// Used by every module of the block; depends on nothing.
package nmof_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_RADIUS  = 7;
  localparam int MAX_HEIGHT  = 4096;
  localparam int STORE_ROWS  = 2 * MAX_RADIUS + 1;
  localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int SROW_W   = $clog2(STORE_ROWS);
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int RAD_W    = 3;
  localparam int THR_W    = 9;
  localparam int PIX_W    = 8;
  localparam int ADDR_W   = SROW_W + COL_W;
  localparam int LAG_W    = 13;
  localparam int SUM_W    = 16;
  localparam int CNT_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_RADIUS    = 2'd2,
    REG_THRESHOLD = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]      width;
    logic [HEIGHT_W-1:0]     height;
    logic [RAD_W-1:0]        radius;
    logic signed [THR_W-1:0] threshold;
  } cfg_eff_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [SROW_W-1:0] srow;
    logic              last;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } wr_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             replaced;
    logic             last;
  } result_t;

  // Clamp raw width, height and radius values to their usable ranges; the threshold is taken as signed.
  function automatic cfg_eff_t eff_cfg(input logic [WIDTH_W-1:0] w,
                                       input logic [HEIGHT_W-1:0] h,
                                       input logic [RAD_W-1:0] r,
                                       input logic [THR_W-1:0] t);
    cfg_eff_t c;
    if (w == '0) c.width = WIDTH_W'(1);
    else if (w > WIDTH_W'(MAX_WIDTH)) c.width = WIDTH_W'(MAX_WIDTH);
    else c.width = w;
    if (h == '0) c.height = HEIGHT_W'(1);
    else if (h > HEIGHT_W'(MAX_HEIGHT)) c.height = HEIGHT_W'(MAX_HEIGHT);
    else c.height = h;
    if (r == '0) c.radius = RAD_W'(1);
    else if (r > RAD_W'(MAX_RADIUS)) c.radius = RAD_W'(MAX_RADIUS);
    else c.radius = r;
    c.threshold = $signed(t);
    return c;
  endfunction

endpackage

// File: src/nmof_rfifo.sv
// Two-entry result queue in front of the output port.
// Depends on nmof_pkg for the result type.
module nmof_rfifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  nmof_pkg::result_t din,
  input  logic              pop,
  output nmof_pkg::result_t dout,
  output logic              empty,
  output logic              full
);
  import nmof_pkg::*;

  result_t    ent_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign empty   = (cnt_r == 2'd0);
  assign full    = (cnt_r == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = ent_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) begin
        ent_r[wptr_r] <= din;
        wptr_r        <= ~wptr_r;
      end
      if (do_pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// File: src/nmof_front.sv
// Front end: takes input transactions, writes the line store, tracks the
// input and output raster positions and issues one window job when due.
// Depends on nmof_pkg.
module nmof_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nmof_pkg::cfg_eff_t           cfg,
  input  logic                         cfg_clear,
  input  logic                         push,
  input  logic [nmof_pkg::PIX_W-1:0]   pixel,
  input  logic                         flush,
  input  logic                         back_busy,
  input  logic                         res_full,
  input  logic                         job_take,
  output logic                         full,
  output nmof_pkg::wr_t                wr,
  output nmof_pkg::job_t               job,
  output logic                         job_valid
);
  import nmof_pkg::*;

  logic [COL_W-1:0]  in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W:0]    in_row_r, in_row_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [SROW_W-1:0] in_srow_r, in_srow_nxt, out_srow_r, out_srow_nxt;
  logic              done_r, done_nxt, done_upd;
  logic [LAG_W-1:0]  delta_r, delta_nxt, delta_upd, lag;
  job_t              job_r, job_nxt;
  logic              job_valid_r, job_valid_nxt;
  logic              accept, store, due, in_col_end, out_last;

  // distance between input and output position at which a window is complete
  assign lag = LAG_W'(LAG_W'(cfg.radius) * (LAG_W'(cfg.width) + LAG_W'(1)));

  assign full      = job_valid_r || back_busy || res_full;
  assign accept    = push && !full;
  assign store     = !flush && !done_r;
  assign job       = job_r;
  assign job_valid = job_valid_r;

  always_comb begin
    in_col_nxt    = in_col_r;
    in_row_nxt    = in_row_r;
    in_srow_nxt   = in_srow_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_srow_nxt  = out_srow_r;
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r && !job_take;
    delta_upd     = delta_r;
    done_upd      = done_r;
    wr.en         = 1'b0;
    wr.addr       = {in_srow_r, in_col_r};
    wr.data       = pixel;
    in_col_end    = (WIDTH_W'(in_col_r) + WIDTH_W'(1)) == cfg.width;
    out_last      = ((HEIGHT_W'(out_row_r) + HEIGHT_W'(1)) == cfg.height) &&
                    ((WIDTH_W'(out_col_r) + WIDTH_W'(1)) == cfg.width);

    if (accept && store) begin
      wr.en     = 1'b1;
      delta_upd = delta_r + LAG_W'(1);
      if (in_col_end) begin
        in_col_nxt  = '0;
        in_row_nxt  = in_row_r + (ROW_W+1)'(1);
        in_srow_nxt = (in_srow_r == SROW_W'(STORE_ROWS - 1)) ? '0 : in_srow_r + SROW_W'(1);
        if ((in_row_r + (ROW_W+1)'(1)) == cfg.height) done_upd = 1'b1;
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
    end

    due       = accept && (done_upd || (delta_upd > lag));
    delta_nxt = delta_upd - LAG_W'(due);
    done_nxt  = done_upd;

    if (due) begin
      job_nxt       = '{row: out_row_r, col: out_col_r, srow: out_srow_r, last: out_last};
      job_valid_nxt = 1'b1;
      if (out_last) begin
        in_col_nxt = '0; in_row_nxt = '0; in_srow_nxt = '0;
        out_col_nxt = '0; out_row_nxt = '0; out_srow_nxt = '0;
        done_nxt = 1'b0; delta_nxt = '0;
      end else if ((WIDTH_W'(out_col_r) + WIDTH_W'(1)) == cfg.width) begin
        out_col_nxt  = '0;
        out_row_nxt  = out_row_r + ROW_W'(1);
        out_srow_nxt = (out_srow_r == SROW_W'(STORE_ROWS - 1)) ? '0 : out_srow_r + SROW_W'(1);
      end else begin
        out_col_nxt = out_col_r + COL_W'(1);
      end
    end

    if (cfg_clear) begin
      in_col_nxt = '0; in_row_nxt = '0; in_srow_nxt = '0;
      out_col_nxt = '0; out_row_nxt = '0; out_srow_nxt = '0;
      done_nxt = 1'b0; delta_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_srow_r   <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_srow_r  <= '0;
      done_r      <= 1'b0;
      delta_r     <= '0;
      job_valid_r <= 1'b0;
    end else begin
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      in_srow_r   <= in_srow_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      out_srow_r  <= out_srow_nxt;
      done_r      <= done_nxt;
      delta_r     <= delta_nxt;
      job_valid_r <= job_valid_nxt;
    end
    job_r <= job_nxt;
  end

endmodule

// File: src/nmof_back.sv
// Back end: owns the line store, scans one window per job a pixel per
// cycle, divides the sum by the neighbor count and makes the decision.
// Depends on nmof_pkg.
module nmof_back (
  input  logic               clk,
  input  logic               rst_n,
  input  nmof_pkg::cfg_eff_t cfg,
  input  nmof_pkg::wr_t      wr,
  input  nmof_pkg::job_t     job,
  input  logic               job_valid,
  output logic               job_take,
  output logic               busy,
  output logic               res_push,
  output nmof_pkg::result_t  res
);
  import nmof_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_WAIT, ST_DIVI, ST_DIV, ST_OUT
  } state_t;

  state_t            state_r;
  logic [PIX_W-1:0]  mem [STORE_DEPTH];
  logic [PIX_W-1:0]  mem_q_r, ctr_pix_r;
  logic [ROW_W-1:0]  y_r, rhi_r, crow_r;
  logic [COL_W-1:0]  x_r, clo_r, chi_r, ccol_r;
  logic [SROW_W-1:0] sy_r;
  logic              last_r, rd_vld_r, rd_ctr_r;
  logic [SUM_W-1:0]  sum_r, quo_r;
  logic [CNT_W-1:0]  n_r, rem_r;
  logic [3:0]        step_r;

  logic [ROW_W-1:0]  rlo, rhi;
  logic [COL_W-1:0]  clo, chi;
  logic [SROW_W-1:0] srlo;
  logic [HEIGHT_W-1:0] rsum;
  logic [WIDTH_W-1:0]  csum;
  logic [CNT_W:0]      rem_sh;
  logic [PIX_W-1:0]    mean;
  logic signed [PIX_W+1:0] diff;
  logic                repl;

  // window bounds, clipped at the frame edges
  always_comb begin
    rsum = HEIGHT_W'(job.row) + HEIGHT_W'(cfg.radius);
    csum = WIDTH_W'(job.col) + WIDTH_W'(cfg.radius);
    rlo  = (job.row >= ROW_W'(cfg.radius)) ? job.row - ROW_W'(cfg.radius) : '0;
    rhi  = (rsum < cfg.height) ? ROW_W'(rsum) : ROW_W'(cfg.height - HEIGHT_W'(1));
    clo  = (job.col >= COL_W'(cfg.radius)) ? job.col - COL_W'(cfg.radius) : '0;
    chi  = (csum < cfg.width) ? COL_W'(csum) : COL_W'(cfg.width - WIDTH_W'(1));
    if (job.row < ROW_W'(cfg.radius)) srlo = '0;
    else if (job.srow >= SROW_W'(cfg.radius)) srlo = job.srow - SROW_W'(cfg.radius);
    else srlo = SROW_W'((SROW_W+1)'(job.srow) + (SROW_W+1)'(STORE_ROWS)
                        - (SROW_W+1)'(cfg.radius));
  end

  assign rem_sh   = {rem_r, quo_r[SUM_W-1]};
  assign mean     = quo_r[PIX_W-1:0];
  assign diff     = $signed({2'b00, ctr_pix_r}) - $signed({2'b00, mean});
  assign repl     = (n_r != '0) && (diff > (PIX_W+2)'(cfg.threshold));
  assign job_take = (state_r == ST_IDLE) && job_valid;
  assign busy     = (state_r != ST_IDLE);
  assign res_push = (state_r == ST_OUT);
  assign res      = '{pixel: repl ? mean : ctr_pix_r, replaced: repl, last: last_r};

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    mem_q_r <= mem[{sy_r, x_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == ST_SCAN);
      rd_ctr_r <= (y_r == crow_r) && (x_r == ccol_r);
      if (rd_vld_r) begin
        if (rd_ctr_r) ctr_pix_r <= mem_q_r;
        else begin
          sum_r <= sum_r + SUM_W'(mem_q_r);
          n_r   <= n_r + CNT_W'(1);
        end
      end
      unique case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            y_r <= rlo; rhi_r <= rhi; sy_r <= srlo;
            x_r <= clo; clo_r <= clo; chi_r <= chi;
            crow_r <= job.row; ccol_r <= job.col; last_r <= job.last;
            sum_r <= '0; n_r <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (x_r == chi_r) begin
            x_r <= clo_r;
            if (y_r == rhi_r) state_r <= ST_WAIT;
            else begin
              y_r  <= y_r + ROW_W'(1);
              sy_r <= (sy_r == SROW_W'(STORE_ROWS - 1)) ? '0 : sy_r + SROW_W'(1);
            end
          end else begin
            x_r <= x_r + COL_W'(1);
          end
        end
        ST_WAIT: state_r <= ST_DIVI;
        ST_DIVI: begin
          quo_r  <= sum_r;
          rem_r  <= '0;
          step_r <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (rem_sh >= {1'b0, n_r}) begin
            rem_r <= CNT_W'(rem_sh - {1'b0, n_r});
            quo_r <= {quo_r[SUM_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[CNT_W-1:0];
            quo_r <= {quo_r[SUM_W-2:0], 1'b0};
          end
          step_r <= step_r + 4'd1;
          if (step_r == 4'd15) state_r <= ST_OUT;
        end
        ST_OUT: state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/neighbor_mean_outlier_filter_core.sv
// Top level of the neighbor-mean outlier filter: configuration registers,
// front end, back end and result queue. Depends on nmof_pkg and submodules.
//
// Gray pixels enter in raster order as push/full transactions; each output
// pixel lags its input by radius*width+radius transactions and flush
// transactions after the frame drain the rest. A transaction that produces
// a result starts a window scan (one line-store read per cycle) and then
// the 16-step serial divider in the back end. A new transaction is taken
// only once the back end has finished the previous window, since the next
// write may land in a row the window still reads. The line store (15 rows
// of 1024 bytes) needs no clearing pass. Config writes (cfg_ready is always
// high) restart the frame; issue them only while the block is idle.
module neighbor_mean_outlier_filter_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [nmof_pkg::PIX_W-1:0]       in_pixel,
  input  logic                             in_flush,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [nmof_pkg::PIX_W-1:0]       out_pixel_out,
  output logic                             out_replaced,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nmof_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nmof_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import nmof_pkg::*;

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [RAD_W-1:0]    radius_r;
  logic [THR_W-1:0]    thresh_r;
  cfg_eff_t            cfg;
  logic                cfg_wr;
  wr_t                 wr;
  job_t                job;
  logic                job_valid, job_take, back_busy;
  logic                res_push, res_full;
  result_t             res, res_q;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg       = eff_cfg(width_r, height_r, radius_r, thresh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_W'(640);
      height_r <= HEIGHT_W'(480);
      radius_r <= RAD_W'(1);
      thresh_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIDTH:     width_r  <= cfg_data[WIDTH_W-1:0];
        REG_HEIGHT:    height_r <= cfg_data[HEIGHT_W-1:0];
        REG_RADIUS:    radius_r <= cfg_data[RAD_W-1:0];
        REG_THRESHOLD: thresh_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  nmof_front u_front (
    .clk, .rst_n, .cfg, .cfg_clear(cfg_wr),
    .push(in_push), .pixel(in_pixel), .flush(in_flush),
    .back_busy, .res_full, .job_take,
    .full(in_full), .wr, .job, .job_valid
  );

  nmof_back u_back (
    .clk, .rst_n, .cfg, .wr, .job, .job_valid,
    .job_take, .busy(back_busy), .res_push, .res
  );

  nmof_rfifo u_rfifo (
    .clk, .rst_n, .push(res_push), .din(res), .pop(out_pop),
    .dout(res_q), .empty(out_empty), .full(res_full)
  );

  assign out_pixel_out = res_q.pixel;
  assign out_replaced  = res_q.replaced;
  assign out_last      = res_q.last;

`ifndef NO_ASSERTIONS
  // a finished window always finds room in the result queue
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result queue overflow");
  // no store write while a window scan is running
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> !back_busy) else $error("line store written during scan");
  // a job is handed over only to an idle back end, one at a time
  a_job_once: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |=> !job_take) else $error("job taken twice");
`endif

endmodule
